@@ rtl/core/tcds_pkg.sv @@
package tcds_pkg;

  localparam int MaxChunksDef = 64;
  localparam int CoordW       = 32;
  localparam int SizeW        = 16;
  localparam int StatusW      = 2;
  localparam int CountOutW    = 7;
  localparam int CfgIdxW      = 1;

  localparam logic OP_TILE   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic KIND_CHUNK   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_BAD_SIZE = 2'd1;
  localparam logic [StatusW-1:0] ST_OVERFLOW = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_CHUNK_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_CHUNK_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_CMP,
    S_MISS,
    S_OUT,
    S_SUM
  } state_t;

  typedef struct packed {
    logic start_div;
    logic scan_clr;
    logic scan_rd;
    logic ins;
    logic set_ovf;
    logic load_chunk;
    logic load_sum;
  } cmd_t;

  typedef struct packed {
    logic size_bad;
    logic div_busy;
    logic scan_end;
    logic hit;
    logic full;
  } sts_t;

endpackage

@@ rtl/core/tcds_ram.sv @@
module tcds_ram #(
  parameter int Width = 64,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/tcds_div.sv @@
// Restoring signed floor divider, one quotient bit per cycle.
module tcds_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tcds_pkg::CoordW-1:0]   dividend,
  input  logic [tcds_pkg::SizeW-1:0]    divisor,
  output logic                          busy,
  output logic [tcds_pkg::CoordW-1:0]   quot
);

  localparam int N  = tcds_pkg::CoordW;
  localparam int DW = tcds_pkg::SizeW;
  localparam int CntW = $clog2(N + 1);

  logic [N-1:0]    num_r, num_nxt;
  logic [DW:0]     rem_r, rem_nxt;
  logic [DW-1:0]   d_r;
  logic            neg_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [DW:0]     rem_sh;
  logic            qbit;

  always_comb begin
    rem_sh  = {rem_r[DW-1:0], num_r[N-1]};
    qbit    = (rem_sh >= {1'b0, d_r});
    rem_nxt = qbit ? (rem_sh - {1'b0, d_r}) : rem_sh;
    num_nxt = {num_r[N-2:0], qbit};
    cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CntW'(N);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[N-1];
      num_r <= dividend[N-1] ? (~dividend + 1'b1) : dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (cnt_r != '0) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  // negative with remainder: -(q+1) == ~q
  assign quot = !neg_r ? num_r : ((rem_r != '0) ? ~num_r : (~num_r + 1'b1));

endmodule

@@ rtl/core/tcds_dp.sv @@
module tcds_dp #(
  parameter int MaxChunks = tcds_pkg::MaxChunksDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tcds_pkg::cmd_t                    cmd,
  output tcds_pkg::sts_t                    sts,
  input  logic                              cfg_we,
  input  logic [tcds_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [tcds_pkg::SizeW-1:0]        cfg_data,
  input  logic [tcds_pkg::CoordW-1:0]       in_tile_x,
  input  logic [tcds_pkg::CoordW-1:0]       in_tile_y,
  output logic                              out_kind,
  output logic [tcds_pkg::CoordW-1:0]       out_chunk_x,
  output logic [tcds_pkg::CoordW-1:0]       out_chunk_y,
  output logic [tcds_pkg::StatusW-1:0]      out_status,
  output logic [tcds_pkg::CountOutW-1:0]    out_chunk_count
);

  localparam int CW    = $clog2(MaxChunks + 1);
  localparam int AW    = (MaxChunks > 1) ? $clog2(MaxChunks) : 1;
  localparam int KeyW  = 2 * tcds_pkg::CoordW;

  logic [tcds_pkg::SizeW-1:0]   cw_r, ch_r;
  logic [CW-1:0]                count_r, idx_r;
  logic                         ovf_r;
  logic [tcds_pkg::CoordW-1:0]  qx, qy;
  logic                         bx, by;
  logic [KeyW-1:0]              key, rdata;
  logic [tcds_pkg::StatusW-1:0] sum_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= tcds_pkg::SizeW'(16);
      ch_r <= tcds_pkg::SizeW'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcds_pkg::REG_CHUNK_WIDTH:  cw_r <= cfg_data;
        tcds_pkg::REG_CHUNK_HEIGHT: ch_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tcds_div u_div_x (
    .clk, .rst_n, .start(cmd.start_div), .dividend(in_tile_x), .divisor(cw_r),
    .busy(bx), .quot(qx)
  );
  tcds_div u_div_y (
    .clk, .rst_n, .start(cmd.start_div), .dividend(in_tile_y), .divisor(ch_r),
    .busy(by), .quot(qy)
  );

  assign key = {qx, qy};

  tcds_ram #(.Width(KeyW), .Depth(MaxChunks)) u_set (
    .clk, .we(cmd.ins), .waddr(count_r[AW-1:0]), .wdata(key),
    .raddr(idx_r[AW-1:0]), .rdata
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else if (cmd.load_sum) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      if (cmd.ins)     count_r <= count_r + 1'b1;
      if (cmd.set_ovf) ovf_r   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      idx_r <= '0;
    end else if (cmd.scan_rd) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  assign sts.size_bad = (cw_r == '0) || (ch_r == '0);
  assign sts.div_busy = bx | by;
  assign sts.scan_end = (idx_r == count_r);
  assign sts.hit      = (rdata == key);
  assign sts.full     = (count_r >= CW'(MaxChunks));

  assign sum_status = sts.size_bad ? tcds_pkg::ST_BAD_SIZE :
                      (ovf_r ? tcds_pkg::ST_OVERFLOW : tcds_pkg::ST_OK);

  // count_r already includes the new chunk when load_chunk fires
  always_ff @(posedge clk) begin
    if (cmd.load_chunk) begin
      out_kind        <= tcds_pkg::KIND_CHUNK;
      out_chunk_x     <= qx;
      out_chunk_y     <= qy;
      out_status      <= tcds_pkg::ST_OK;
      out_chunk_count <= tcds_pkg::CountOutW'(count_r);
    end else if (cmd.load_sum) begin
      out_kind        <= tcds_pkg::KIND_SUMMARY;
      out_chunk_x     <= '0;
      out_chunk_y     <= '0;
      out_status      <= sum_status;
      out_chunk_count <= tcds_pkg::CountOutW'(count_r);
    end
  end

endmodule

@@ rtl/core/tcds_ctrl.sv @@
module tcds_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_op,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  tcds_pkg::sts_t sts,
  output tcds_pkg::cmd_t cmd
);

  tcds_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free, acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcds_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != tcds_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign acc       = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      tcds_pkg::S_IDLE: begin
        if (acc) begin
          if (in_op == tcds_pkg::OP_FINISH) begin
            state_nxt = tcds_pkg::S_SUM;
          end else if (!sts.size_bad) begin
            cmd.start_div = 1'b1;
            state_nxt     = tcds_pkg::S_DIV;
          end
        end
      end
      tcds_pkg::S_DIV: begin
        cmd.scan_clr = 1'b1;
        if (!sts.div_busy) state_nxt = tcds_pkg::S_SCAN;
      end
      tcds_pkg::S_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = tcds_pkg::S_MISS;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = tcds_pkg::S_CMP;
        end
      end
      tcds_pkg::S_CMP: begin
        state_nxt = sts.hit ? tcds_pkg::S_IDLE : tcds_pkg::S_SCAN;
      end
      tcds_pkg::S_MISS: begin
        if (sts.full) begin
          cmd.set_ovf = 1'b1;
          state_nxt   = tcds_pkg::S_IDLE;
        end else begin
          cmd.ins   = 1'b1;
          state_nxt = tcds_pkg::S_OUT;
        end
      end
      tcds_pkg::S_OUT: begin
        if (out_free) begin
          cmd.load_chunk = 1'b1;
          state_nxt      = tcds_pkg::S_IDLE;
        end
      end
      tcds_pkg::S_SUM: begin
        if (out_free) begin
          cmd.load_sum = 1'b1;
          state_nxt    = tcds_pkg::S_IDLE;
        end
      end
      default: state_nxt = tcds_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.load_chunk || cmd.load_sum) out_valid_nxt = 1'b1;
  end

endmodule

@@ rtl/core/tile_to_chunk_dirty_set_core.sv @@
// Dirty-chunk set: maps changed tiles to chunks and reports each chunk once
// per query.
// Input channel (in_valid/in_stall): one word per item, in_op selects a
// changed tile (tile_x, tile_y) or a finish that emits a summary and clears
// the set. Output channel (out_valid/out_stall): a newly dirty chunk word or a
// summary word carrying status and chunk count.
// Config port: cfg_we writes chunk_width (index 0) or chunk_height (index 1);
// write only while the block is idle.
// Operation: a tile runs two floor dividers in parallel, then scans the
// stored chunks in the set RAM, reading and comparing one entry at a time.
// A tile that arrives while a chunk size is zero is ignored.
// One item at a time; in_stall is high while an item is at work.
// The result sits in an output register; the next item is accepted while it
// waits, and the block holds in its last state if the receiver still stalls.
// Reset: sizes return to 16x16, the set is empty, no output valid. The set
// RAM needs no clearing pass; only entries below the count are read.
module tile_to_chunk_dirty_set_core #(
  parameter int MaxChunks = tcds_pkg::MaxChunksDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_op,
  input  logic signed [tcds_pkg::CoordW-1:0] in_tile_x,
  input  logic signed [tcds_pkg::CoordW-1:0] in_tile_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_kind,
  output logic signed [tcds_pkg::CoordW-1:0] out_chunk_x,
  output logic signed [tcds_pkg::CoordW-1:0] out_chunk_y,
  output logic [tcds_pkg::StatusW-1:0]      out_status,
  output logic [tcds_pkg::CountOutW-1:0]    out_chunk_count,
  input  logic                              cfg_we,
  input  logic [tcds_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [tcds_pkg::SizeW-1:0]        cfg_data
);

  tcds_pkg::cmd_t cmd;
  tcds_pkg::sts_t sts;

  tcds_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_op, .in_stall, .out_valid, .out_stall,
    .sts, .cmd
  );

  tcds_dp #(.MaxChunks(MaxChunks)) u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_we, .cfg_index, .cfg_data,
    .in_tile_x(in_tile_x), .in_tile_y(in_tile_y),
    .out_kind, .out_chunk_x, .out_chunk_y, .out_status, .out_chunk_count
  );

endmodule

@@ rtl/core/tcds_checker.sv @@
module tcds_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           in_op,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_kind,
  input logic [tcds_pkg::CoordW-1:0]    out_chunk_x,
  input logic [tcds_pkg::CoordW-1:0]    out_chunk_y,
  input logic [tcds_pkg::StatusW-1:0]   out_status,
  input logic [tcds_pkg::CountOutW-1:0] out_chunk_count
);

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_chunk_x) && $stable(out_chunk_y) && $stable(out_status) &&
      $stable(out_chunk_count))
    else $error("stalled output word changed");

  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_op == tcds_pkg::OP_FINISH |=> in_stall)
    else $error("finish did not occupy the block");

  a_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == tcds_pkg::KIND_SUMMARY |->
      out_chunk_x == '0 && out_chunk_y == '0)
    else $error("summary carries coordinates");

  a_chunk_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == tcds_pkg::KIND_CHUNK |->
      out_status == tcds_pkg::ST_OK && out_chunk_count != '0)
    else $error("chunk word with bad status or zero count");

endmodule

bind tile_to_chunk_dirty_set_core tcds_checker u_tcds_checker (.*);

@@ verif/tb_tile_to_chunk_dirty_set_core.sv @@
`timescale 1ns / 100ps

module tb_tile_to_chunk_dirty_set_core;
  import tcds_pkg::*;

  localparam int MaxChunks = MaxChunksDef;
  localparam int SettleCycles = 200;  // longer than the worst-case time to process one tile

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_op;
  logic signed [CoordW-1:0]  in_tile_x;
  logic signed [CoordW-1:0]  in_tile_y;
  logic                      out_valid;
  logic                      out_stall;
  logic                      out_kind;
  logic signed [CoordW-1:0]  out_chunk_x;
  logic signed [CoordW-1:0]  out_chunk_y;
  logic [StatusW-1:0]        out_status;
  logic [CountOutW-1:0]      out_chunk_count;
  logic                      cfg_we;
  logic [CfgIdxW-1:0]        cfg_index;
  logic [SizeW-1:0]          cfg_data;

  tile_to_chunk_dirty_set_core #(.MaxChunks(MaxChunks)) dut (.*);

  // One output word as the checker sees it.
  typedef struct packed {
    logic                     kind;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic [StatusW-1:0]       status;
    logic [CountOutW-1:0]     count;
  } chunk_word_t;

  // Directed stimulus row. has_exp marks rows with a typed-in result.
  typedef struct {
    logic                     op;
    logic signed [CoordW-1:0] tx;
    logic signed [CoordW-1:0] ty;
    bit                       has_exp;
    chunk_word_t              exp;
  } dir_row_t;

  chunk_word_t pending_words[$];
  int          err_cnt;

  // Shadow of the block state.
  logic [SizeW-1:0] sh_width, sh_height;
  logic [63:0]      sh_chunks[MaxChunks];
  int               sh_count;
  bit               sh_ovf;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Signed floor division of a tile coordinate by a nonzero chunk size.
  function automatic logic [31:0] floor_div(logic signed [31:0] n, logic [15:0] d);
    longint q, r;
    q = longint'(n) / longint'(d);
    r = longint'(n) % longint'(d);
    if (r < 0) q = q - 1;
    return q[31:0];
  endfunction

  // Predict the word caused by one accepted item; returns 0 when none.
  function automatic bit map_tile(logic op, logic signed [31:0] tx,
                                  logic signed [31:0] ty, output chunk_word_t w);
    bit          bad;
    logic [31:0] cx, cy;
    logic [63:0] key;
    bad = (sh_width == 0) || (sh_height == 0);
    w = '0;
    if (op == OP_FINISH) begin
      w.kind   = KIND_SUMMARY;
      w.status = bad ? ST_BAD_SIZE : (sh_ovf ? ST_OVERFLOW : ST_OK);
      w.count  = sh_count[CountOutW-1:0];
      sh_count = 0;
      sh_ovf   = 0;
      return 1;
    end
    if (bad) return 0;
    cx  = floor_div(tx, sh_width);
    cy  = floor_div(ty, sh_height);
    key = {cx, cy};
    for (int i = 0; i < sh_count; i++)
      if (sh_chunks[i] == key) return 0;
    if (sh_count >= MaxChunks) begin
      sh_ovf = 1;
      return 0;
    end
    sh_chunks[sh_count] = key;
    sh_count++;
    w.kind  = KIND_CHUNK;
    w.cx    = cx;
    w.cy    = cy;
    w.count = sh_count[CountOutW-1:0];
    return 1;
  endfunction

  // Receiver stall pattern: randomly switching stretches of no, light and heavy stall.
  int stall_mode;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Output checker.
  always @(posedge clk) begin
    chunk_word_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_kind, out_chunk_x, out_chunk_y, out_status, out_chunk_count};
      if (pending_words.size() == 0) begin
        $display("%0t unexpected word: actual %h", $time, got);
        err_cnt++;
      end else begin
        want = pending_words.pop_front();
        if (got.kind != want.kind || got.cx != want.cx || got.cy != want.cy ||
            got.status != want.status || got.count != want.count) begin
          $display("%0t mismatch: expected kind=%0d x=%0d y=%0d st=%0d n=%0d",
                   $time, want.kind, want.cx, want.cy, want.status, want.count);
          $display("%0t           actual   kind=%0d x=%0d y=%0d st=%0d n=%0d",
                   $time, got.kind, got.cx, got.cy, got.status, got.count);
          err_cnt++;
        end
      end
    end
  end

  // Send one item, predicting at acceptance. Optional typed-in expectation.
  task automatic send_word(logic op, logic signed [31:0] tx, logic signed [31:0] ty,
                           bit has_exp = 0, chunk_word_t exp = '0);
    chunk_word_t w;
    bit          hit;
    in_valid  <= 1'b1;
    in_op     <= op;
    in_tile_x <= tx;
    in_tile_y <= ty;
    do @(posedge clk); while (in_stall);
    hit = map_tile(op, tx, ty, w);
    if (has_exp && (!hit || w != exp)) begin
      $display("%0t table row disagrees: expected %h, predicted %h", $time, exp, w);
      err_cnt++;
    end
    if (hit) pending_words = {pending_words, w};
  endtask

  task automatic idle_cycles(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drain, let the block settle, then write a register.
  task automatic write_size(logic [CfgIdxW-1:0] idx, logic [SizeW-1:0] val);
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_words.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CHUNK_WIDTH) sh_width = val; else sh_height = val;
  endtask

  function automatic chunk_word_t mk(logic k, int x, int y, logic [1:0] s, int n);
    mk = {k, x[31:0], y[31:0], s, n[6:0]};
  endfunction

  // Random coordinate: mostly clustered so chunks repeat, sometimes extreme.
  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 9))
      0: rnd_coord = $urandom;
      1: rnd_coord = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 40)
                                          : 32'h7FFF_FFFF - $urandom_range(0, 40);
      default: rnd_coord = $urandom_range(0, 120) - 60;
    endcase
  endfunction

  function automatic logic [15:0] rnd_size();
    case ($urandom_range(0, 5))
      0: rnd_size = 1;
      1: rnd_size = 16'hFFFF;
      2: rnd_size = $urandom;
      default: rnd_size = $urandom_range(1, 20);
    endcase
  endfunction

  dir_row_t dir_rows[$];
  int       sent;
  int       qlen;

  initial begin
    err_cnt    = 0;
    stall_mode = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_op      = OP_TILE;
    in_tile_x  = '0;
    in_tile_y  = '0;
    cfg_we     = 1'b0;
    cfg_index  = REG_CHUNK_WIDTH;
    cfg_data   = '0;
    sh_width   = 16;
    sh_height  = 16;
    sh_count   = 0;
    sh_ovf     = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset size 16x16.
    dir_rows = '{
      '{OP_FINISH, 0, 0, 1, mk(KIND_SUMMARY, 0, 0, ST_OK, 0)},
      '{OP_TILE, 0, 0, 1, mk(KIND_CHUNK, 0, 0, ST_OK, 1)},
      '{OP_TILE, 15, 15, 0, '0},                   // same chunk, nothing
      '{OP_TILE, -1, -1, 1, mk(KIND_CHUNK, -1, -1, ST_OK, 2)},
      '{OP_TILE, 32'sh7FFF_FFFF, 32'sh8000_0000, 1,
        mk(KIND_CHUNK, 32'h07FF_FFFF, 32'hF800_0000, ST_OK, 3)},
      '{OP_TILE, -16, -17, 0, '0},
      '{OP_FINISH, 32'sh7FFF_FFFF, -1, 1, mk(KIND_SUMMARY, 0, 0, ST_OK, 4)}
    };
    foreach (dir_rows[i])
      send_word(dir_rows[i].op, dir_rows[i].tx, dir_rows[i].ty,
                dir_rows[i].has_exp, dir_rows[i].exp);

    // Invalid size: tiles ignored, finish reports bad size.
    write_size(REG_CHUNK_WIDTH, 0);
    send_word(OP_TILE, 5, 5);
    send_word(OP_FINISH, 0, 0, 1, mk(KIND_SUMMARY, 0, 0, ST_BAD_SIZE, 0));
    write_size(REG_CHUNK_WIDTH, 1);
    write_size(REG_CHUNK_HEIGHT, 0);
    send_word(OP_TILE, 5, 5);
    send_word(OP_FINISH, 0, 0, 1, mk(KIND_SUMMARY, 0, 0, ST_BAD_SIZE, 0));

    // Size 1x1: fill the table, then overflow.
    write_size(REG_CHUNK_HEIGHT, 1);
    for (int i = 0; i < MaxChunks + 2; i++) send_word(OP_TILE, i, -i);
    send_word(OP_FINISH, 0, 0, 1, mk(KIND_SUMMARY, 0, 0, ST_OVERFLOW, MaxChunks));

    // Largest sizes, then size going bad mid-query (count kept).
    write_size(REG_CHUNK_WIDTH, 16'hFFFF);
    write_size(REG_CHUNK_HEIGHT, 16'hFFFF);
    send_word(OP_TILE, 32'sh8000_0000, 32'sh7FFF_FFFF);
    send_word(OP_TILE, -65536, 65535);
    write_size(REG_CHUNK_HEIGHT, 0);
    send_word(OP_FINISH, 0, 0, 1, mk(KIND_SUMMARY, 0, 0, ST_BAD_SIZE, 2));
    write_size(REG_CHUNK_HEIGHT, 3);

    // Random part: queries of random length in bursts with gaps.
    sent = 0;
    while (sent < 1400) begin
      if ($urandom_range(0, 9) == 0) begin
        write_size($urandom_range(0, 1) ? REG_CHUNK_WIDTH : REG_CHUNK_HEIGHT,
                   ($urandom_range(0, 19) == 0) ? 16'd0 : rnd_size());
      end
      qlen = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 90) : $urandom_range(0, 30);
      for (int i = 0; i < qlen; i++) begin
        send_word(OP_TILE, rnd_coord(), rnd_coord());
        sent++;
        if ($urandom_range(0, 7) == 0) idle_cycles($urandom_range(1, 50));
      end
      send_word(OP_FINISH, $urandom, $urandom);
      sent++;
      if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 80));
    end
    in_valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/tcds_pkg.sv
rtl/core/tcds_ram.sv
rtl/core/tcds_div.sv
rtl/core/tcds_dp.sv
rtl/core/tcds_ctrl.sv
rtl/core/tile_to_chunk_dirty_set_core.sv
rtl/core/tcds_checker.sv
verif/tb_tile_to_chunk_dirty_set_core.sv
